// File: design/mdap_pkg.sv
// package for the mmio device argument parser: state types, codes and character helpers
`timescale 1ns / 1ps

package mdap_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int ERROR_W  = 4;
    localparam int RESULT_W = 4 * VALUE_W + ERROR_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    typedef enum logic [2:0]
    {
        FP_SIZE,
        FP_AT,
        FP_BASE,
        FP_IRQ,
        FP_ID,
        FP_END,
        FP_DONE
    } field_phase_t;

    typedef enum logic [2:0]
    {
        NP_SPACE,
        NP_SIGN,
        NP_ZERO,
        NP_HEX,
        NP_DIGITS
    } number_phase_t;

    typedef enum logic [1:0]
    {
        RADIX_8,
        RADIX_10,
        RADIX_16
    } radix_t;

    typedef enum logic [ERROR_W-1:0]
    {
        ERR_NONE,
        ERR_BAD_SIZE,
        ERR_NO_AT,
        ERR_BAD_BASE,
        ERR_NO_COLON,
        ERR_BAD_IRQ,
        ERR_BAD_ID_SEP,
        ERR_BAD_ID,
        ERR_TRAILING
    } err_code_t;

    typedef struct packed
    {
        field_phase_t      fphase;
        number_phase_t     nphase;
        radix_t            radix;
        logic              negate;
        logic [VALUE_W-1:0] acc;
        logic              overflowed;
        logic [VALUE_W-1:0] size_value;
        logic [VALUE_W-1:0] base_value;
        logic [VALUE_W-1:0] irq_value;
        logic [VALUE_W-1:0] id_value;
        err_code_t         err;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        fphase:     FP_SIZE,
        nphase:     NP_SPACE,
        radix:      RADIX_10,
        negate:     1'b0,
        acc:        '0,
        overflowed: 1'b0,
        size_value: '0,
        base_value: '0,
        irq_value:  '0,
        id_value:   '0,
        err:        ERR_NONE
    };

    // digit value of a character, 16 when it is no hex digit
    function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c inside {["0":"9"]})
        begin
            d = 5'(c - "0");
        end
        else if (c inside {["a":"f"]})
        begin
            d = 5'(c - "a" + 8'd10);
        end
        else if (c inside {["A":"F"]})
        begin
            d = 5'(c - "A" + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_value(input radix_t r);
        logic [4:0] v;
        case (r)
            RADIX_8:  v = 5'd8;
            RADIX_16: v = 5'd16;
            default:  v = 5'd10;
        endcase
        return v;
    endfunction

    // left shift for a size suffix, zero when the character is none
    function automatic logic [5:0] suffix_shift(input logic [CHAR_W-1:0] c);
        logic [5:0] sh;
        case (c)
            "K", "k": sh = 6'd10;
            "M", "m": sh = 6'd20;
            "G", "g": sh = 6'd30;
            "T", "t": sh = 6'd40;
            "P", "p": sh = 6'd50;
            "E", "e": sh = 6'd60;
            default:  sh = 6'd0;
        endcase
        return sh;
    endfunction

endpackage

// File: design/mmio_device_arg_parser.sv
// top level of the mmio device argument parser: character stream in, parsed values out
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata = char_code, s_tlast = last_char
//  m_*      out  m_tvalid/m_tready   m_tdata = region_size, base_address, irq_number,
//                                    device_id, error_code
//
// one character is taken per cycle while s_tready is high; a result appears the cycle after its last character
// the parse state is updated in one pass of logic straight from the accepted request
// the result register is reloaded in the cycle it is taken, so arguments follow with no gap
// s_tready drops only while a result is held and m_tready is low
// reset puts the parser at the start of a size number and clears any pending result
`timescale 1ns / 1ps

module mmio_device_arg_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mdap_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                        s_tlast,   // last_char
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [63:0] region_size, [127:64] base_address, [191:128] irq_number,
    // [255:192] device_id, [259:256] error_code, upper bits zero
    output logic [mdap_pkg::TDATA_W-1:0] m_tdata
);

    localparam int VW = mdap_pkg::VALUE_W;

    mdap_pkg::parse_state_t state_reg;
    mdap_pkg::parse_state_t state_next;
    mdap_pkg::parse_state_t step_state;
    mdap_pkg::parse_state_t final_state;

    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [mdap_pkg::TDATA_W-1:0] m_tdata_reg;
    logic [mdap_pkg::TDATA_W-1:0] m_tdata_next;
    logic                         s_accept;

    function automatic mdap_pkg::parse_state_t start_number(
        input mdap_pkg::parse_state_t s,
        input mdap_pkg::field_phase_t next_field
    );
        mdap_pkg::parse_state_t n;
        n = s;
        n.fphase     = next_field;
        n.nphase     = mdap_pkg::NP_SPACE;
        n.radix      = mdap_pkg::RADIX_10;
        n.negate     = 1'b0;
        n.acc        = '0;
        n.overflowed = 1'b0;
        return n;
    endfunction

    // no digits, overflow, zero or all ones; decided on the accumulator so the negate is off this path
    function automatic logic number_bad(input mdap_pkg::parse_state_t s);
        logic bad;
        if (s.nphase != mdap_pkg::NP_DIGITS || s.overflowed)
        begin
            bad = 1'b1;
        end
        else if (s.negate)
        begin
            bad = (s.acc == '0) || (s.acc == VW'(1));
        end
        else
        begin
            bad = (s.acc == '0) || (s.acc == mdap_pkg::ALL_ONES);
        end
        return bad;
    endfunction

    function automatic logic [VW-1:0] number_value(input mdap_pkg::parse_state_t s);
        logic [VW-1:0] v;
        if (s.nphase != mdap_pkg::NP_DIGITS)
        begin
            v = '0;
        end
        else if (s.overflowed)
        begin
            v = mdap_pkg::ALL_ONES;
        end
        else if (s.negate)
        begin
            v = '0 - s.acc;
        end
        else
        begin
            v = s.acc;
        end
        return v;
    endfunction

    // files the finished number under its field and flags it when bad
    function automatic mdap_pkg::parse_state_t store_number(input mdap_pkg::parse_state_t s);
        mdap_pkg::parse_state_t n;
        logic [VW-1:0]          v;
        mdap_pkg::err_code_t    code;
        n = s;
        v = number_value(s);
        case (s.fphase)
            mdap_pkg::FP_SIZE:
            begin
                n.size_value = v;
                code = mdap_pkg::ERR_BAD_SIZE;
            end
            mdap_pkg::FP_BASE:
            begin
                n.base_value = v;
                code = mdap_pkg::ERR_BAD_BASE;
            end
            mdap_pkg::FP_IRQ:
            begin
                n.irq_value = v;
                code = mdap_pkg::ERR_BAD_IRQ;
            end
            default:
            begin
                n.id_value = v;
                code = mdap_pkg::ERR_BAD_ID;
            end
        endcase
        if (number_bad(s))
        begin
            n.err = code;
        end
        return n;
    endfunction

    function automatic mdap_pkg::parse_state_t feed_char(
        input mdap_pkg::parse_state_t s,
        input logic [mdap_pkg::CHAR_W-1:0] c
    );
        mdap_pkg::parse_state_t n;
        logic [4:0]             d;
        logic                   ends;
        logic                   sign_path;
        logic [VW+3:0]          wide;
        logic [VW+3:0]          prod;
        logic [5:0]             sh;
        n         = s;
        d         = mdap_pkg::digit_of(c);
        ends      = 1'b0;
        sign_path = 1'b0;
        wide      = {4'b0, s.acc};
        prod      = '0;
        sh        = mdap_pkg::suffix_shift(c);
        if (s.err != mdap_pkg::ERR_NONE || s.fphase == mdap_pkg::FP_DONE)
        begin
            n = s;
        end
        else if (s.fphase == mdap_pkg::FP_AT)
        begin
            if (c == "@")
            begin
                n = start_number(s, mdap_pkg::FP_BASE);
            end
            else
            begin
                n.err = mdap_pkg::ERR_NO_AT;
            end
        end
        else if (s.fphase == mdap_pkg::FP_END)
        begin
            n.err = mdap_pkg::ERR_TRAILING;
        end
        else
        begin
            case (s.nphase)
                mdap_pkg::NP_SPACE:
                begin
                    if (c == " " || c inside {[8'd9:8'd13]})
                    begin
                        ends = 1'b0;
                    end
                    else if (c == "+" || c == "-")
                    begin
                        n.negate = (c == "-");
                        n.nphase = mdap_pkg::NP_SIGN;
                    end
                    else
                    begin
                        sign_path = 1'b1;
                    end
                end
                mdap_pkg::NP_SIGN:
                begin
                    sign_path = 1'b1;
                end
                mdap_pkg::NP_ZERO:
                begin
                    if (c == "x" || c == "X")
                    begin
                        n.nphase = mdap_pkg::NP_HEX;
                        n.radix  = mdap_pkg::RADIX_16;
                    end
                    else if (d < 5'd8)
                    begin
                        n.acc    = VW'(d);
                        n.nphase = mdap_pkg::NP_DIGITS;
                    end
                    else
                    begin
                        ends = 1'b1;
                    end
                end
                mdap_pkg::NP_HEX:
                begin
                    if (d < 5'd16)
                    begin
                        n.acc    = VW'(d);
                        n.nphase = mdap_pkg::NP_DIGITS;
                    end
                    else
                    begin
                        ends = 1'b1;
                    end
                end
                default:
                begin
                    if (d < mdap_pkg::radix_value(s.radix))
                    begin
                        // acc * radix + digit as shifts and adds, overflow in the top bits
                        case (s.radix)
                            mdap_pkg::RADIX_8:  prod = wide << 3;
                            mdap_pkg::RADIX_16: prod = wide << 4;
                            default:            prod = (wide << 3) + (wide << 1);
                        endcase
                        prod = prod + (VW+4)'(d);
                        if (prod[VW+3:VW] != 4'b0)
                        begin
                            n.overflowed = 1'b1;
                        end
                        else
                        begin
                            n.acc = prod[VW-1:0];
                        end
                    end
                    else
                    begin
                        ends = 1'b1;
                    end
                end
            endcase
            if (sign_path)
            begin
                if (c == "0")
                begin
                    n.nphase = mdap_pkg::NP_ZERO;
                    n.radix  = mdap_pkg::RADIX_8;
                end
                else if (d >= 5'd1 && d <= 5'd9)
                begin
                    n.radix  = mdap_pkg::RADIX_10;
                    n.acc    = VW'(d);
                    n.nphase = mdap_pkg::NP_DIGITS;
                end
                else
                begin
                    ends = 1'b1;
                end
            end
            // the ending character did not touch the number, so n still equals s here
            if (ends)
            begin
                n = store_number(s);
                if (n.err == mdap_pkg::ERR_NONE)
                begin
                    case (s.fphase)
                        mdap_pkg::FP_SIZE:
                        begin
                            if (sh != 6'd0)
                            begin
                                n.size_value = n.size_value << sh;
                                n.fphase     = mdap_pkg::FP_AT;
                            end
                            else if (c == "@")
                            begin
                                n = start_number(n, mdap_pkg::FP_BASE);
                            end
                            else
                            begin
                                n.err = mdap_pkg::ERR_NO_AT;
                            end
                        end
                        mdap_pkg::FP_BASE:
                        begin
                            if (c == ":")
                            begin
                                n = start_number(n, mdap_pkg::FP_IRQ);
                            end
                            else
                            begin
                                n.err = mdap_pkg::ERR_NO_COLON;
                            end
                        end
                        mdap_pkg::FP_IRQ:
                        begin
                            if (c == ":")
                            begin
                                n = start_number(n, mdap_pkg::FP_ID);
                            end
                            else
                            begin
                                n.err = mdap_pkg::ERR_BAD_ID_SEP;
                            end
                        end
                        default:
                        begin
                            n.err = mdap_pkg::ERR_TRAILING;
                        end
                    endcase
                end
            end
        end
        return n;
    endfunction

    // end of text: close the open number and check what is missing
    function automatic mdap_pkg::parse_state_t end_text(input mdap_pkg::parse_state_t s);
        mdap_pkg::parse_state_t n;
        n = s;
        if (s.err == mdap_pkg::ERR_NONE && s.fphase != mdap_pkg::FP_DONE)
        begin
            case (s.fphase)
                mdap_pkg::FP_SIZE:
                begin
                    n = store_number(s);
                    if (n.err == mdap_pkg::ERR_NONE)
                    begin
                        n.err = mdap_pkg::ERR_NO_AT;
                    end
                end
                mdap_pkg::FP_AT:
                begin
                    n.err = mdap_pkg::ERR_NO_AT;
                end
                mdap_pkg::FP_BASE:
                begin
                    n = store_number(s);
                    if (n.err == mdap_pkg::ERR_NONE)
                    begin
                        n.err = mdap_pkg::ERR_NO_COLON;
                    end
                end
                mdap_pkg::FP_IRQ:
                begin
                    n = store_number(s);
                    if (n.err == mdap_pkg::ERR_NONE)
                    begin
                        n.id_value = '0;
                    end
                end
                mdap_pkg::FP_ID:
                begin
                    n = store_number(s);
                end
                default:
                begin
                    n = s;
                end
            endcase
            n.fphase = mdap_pkg::FP_DONE;
        end
        return n;
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        // a zero byte ends the text; later characters then find the parser done
        if (s_tdata == '0)
        begin
            step_state = end_text(state_reg);
        end
        else
        begin
            step_state = feed_char(state_reg, s_tdata);
        end
        final_state   = end_text(step_state);
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (s_accept)
        begin
            if (s_tlast)
            begin
                state_next    = mdap_pkg::PARSE_RESET;
                m_tvalid_next = 1'b1;
                m_tdata_next  = mdap_pkg::TDATA_W'({final_state.err,
                                                    final_state.id_value,
                                                    final_state.irq_value,
                                                    final_state.base_value,
                                                    final_state.size_value});
            end
            else
            begin
                state_next = step_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mdap_pkg::PARSE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // a character that is not the last never produces a result
    a_no_result_midway: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_tlast && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("result raised by a character that was not the last");

    // the last character always produces a result next cycle
    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> m_tvalid_reg)
        else $error("no result after the last character");

    // after a result the parser starts over
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> (state_reg == mdap_pkg::PARSE_RESET))
        else $error("parser state not cleared after a result");

    // a clean result carries a usable base and irq
    a_ok_values_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_tdata_reg[4*VW +: mdap_pkg::ERROR_W] == mdap_pkg::ERR_NONE))
        |-> (m_tdata_reg[VW +: VW] != '0) && (m_tdata_reg[VW +: VW] != mdap_pkg::ALL_ONES)
            && (m_tdata_reg[2*VW +: VW] != '0)
            && (m_tdata_reg[2*VW +: VW] != mdap_pkg::ALL_ONES))
        else $error("ok result with a bad base or irq value");

endmodule
